// ===== hdl/itda_pkg.sv =====
`timescale 1ns / 1ps
// itda_pkg: shared types and constants for the integer to decimal ascii block
// no dependencies; used by controller, datapath, interfaces and top level

package itda_pkg;

	localparam int unsigned VALUE_BITS = 64;
	localparam int unsigned CHAR_BITS  = 6;

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} itda_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic shift;
		logic skip;
		logic emit_sign;
		logic emit_digit;
	} itda_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic conv_done;
		logic top_zero;
		logic cnt_one;
		logic negative;
		logic out_free;
	} itda_sts_t;

endpackage

// ===== hdl/itda_in_if.sv =====
`timescale 1ns / 1ps
// itda_in_if: input channel carrying one signed integer per transfer
// depends on itda_pkg

interface itda_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [itda_pkg::VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ===== hdl/itda_out_if.sv =====
`timescale 1ns / 1ps
// itda_out_if: output channel carrying one ascii character per transfer
// depends on itda_pkg

interface itda_out_if;
	logic                            valid;
	logic                            ready;
	logic [itda_pkg::CHAR_BITS-1:0]  character;
	logic                            last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

// ===== hdl/itda_ctrl.sv =====
`timescale 1ns / 1ps
// itda_ctrl: sequencing state machine for load, conversion, zero skip and emission
// depends on itda_pkg

module itda_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  itda_pkg::itda_sts_t sts,
	output itda_pkg::itda_cmd_t cmd
);

	itda_pkg::itda_state_t state_q;
	itda_pkg::itda_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			itda_pkg::ST_IDLE: begin
				if (in_valid) state_d = itda_pkg::ST_CONV;
			end
			itda_pkg::ST_CONV: begin
				if (sts.conv_done) state_d = itda_pkg::ST_SKIP;
			end
			itda_pkg::ST_SKIP: begin
				if (!sts.top_zero || sts.cnt_one) begin
					state_d = sts.negative ? itda_pkg::ST_SIGN : itda_pkg::ST_DIGIT;
				end
			end
			itda_pkg::ST_SIGN: begin
				if (sts.out_free) state_d = itda_pkg::ST_DIGIT;
			end
			itda_pkg::ST_DIGIT: begin
				if (sts.out_free && sts.cnt_one) state_d = itda_pkg::ST_IDLE;
			end
			default: state_d = itda_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			itda_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			itda_pkg::ST_CONV: begin
				cmd.shift = !sts.conv_done;
			end
			itda_pkg::ST_SKIP: begin
				// drop leading zero digits, always keep the final one
				cmd.skip = sts.top_zero && !sts.cnt_one;
			end
			itda_pkg::ST_SIGN: begin
				cmd.emit_sign = sts.out_free;
			end
			itda_pkg::ST_DIGIT: begin
				cmd.emit_digit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== hdl/itda_dp.sv =====
`timescale 1ns / 1ps
// itda_dp: magnitude register, serial shift-and-add-3 bcd converter, output register
// depends on itda_pkg

module itda_dp #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [itda_pkg::VALUE_BITS-1:0] value,
	input  logic                                   out_ready,
	input  itda_pkg::itda_cmd_t                    cmd,
	output itda_pkg::itda_sts_t                    sts,
	output logic                                   out_valid,
	output logic [itda_pkg::CHAR_BITS-1:0]         character,
	output logic                                   last
);

	// decimal digits of 2^(VALUE_WIDTH-1), floor(n*log10(2)) + 1
	localparam int unsigned NDIG   = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
	localparam int unsigned BCD_W  = NDIG * 4;
	localparam int unsigned BCNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned DCNT_W = $clog2(NDIG + 1);

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic [BCNT_W-1:0]      bit_cnt_q;
	logic [DCNT_W-1:0]      dig_cnt_q;
	logic                   neg_q;
	logic [3:0]             top_digit;
	logic                   ovalid_q;
	logic [itda_pkg::CHAR_BITS-1:0] char_q;
	logic                   last_q;

	assign raw       = value[VALUE_WIDTH-1:0];
	assign top_digit = bcd_q[BCD_W-1 -: 4];

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else if (cmd.load) begin
			bit_cnt_q <= BCNT_W'(VALUE_WIDTH);
			dig_cnt_q <= DCNT_W'(NDIG);
		end else begin
			if (cmd.shift) bit_cnt_q <= bit_cnt_q - BCNT_W'(1);
			if (cmd.skip || cmd.emit_digit) dig_cnt_q <= dig_cnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= raw[VALUE_WIDTH-1];
			// unsigned negate, so the most negative value keeps its full magnitude
			mag_q <= raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
			bcd_q <= '0;
		end else if (cmd.shift) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end else if (cmd.skip || cmd.emit_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	// output register, refilled in the cycle its content transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= itda_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= itda_pkg::CHAR_ZERO + {2'b00, top_digit};
			last_q <= (dig_cnt_q == DCNT_W'(1));
		end
	end

	assign sts.conv_done = (bit_cnt_q == '0);
	assign sts.top_zero  = (top_digit == 4'd0);
	assign sts.cnt_one   = (dig_cnt_q == DCNT_W'(1));
	assign sts.negative  = neg_q;
	assign sts.out_free  = !ovalid_q || out_ready;

	assign out_valid = ovalid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

// ===== hdl/int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// Signed integer to decimal ascii text, one character per output transfer, most
// significant first, with a leading '-' for negative values and last on the final digit.
// The low VALUE_WIDTH bits of each input value are converted, bit VALUE_WIDTH-1 being the
// sign. One value is handled at a time: the shift-and-add-3 bcd converter takes one
// magnitude bit per cycle, then the digit register is walked one digit per cycle while
// the output is not stalled. The next value is accepted as soon as the final character
// sits in the output register. Nothing is kept between values.
// depends on itda_pkg, itda_in_if, itda_out_if, itda_ctrl, itda_dp

module int_to_decimal_ascii #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	itda_in_if.sink    number,
	itda_out_if.source text
);

	itda_pkg::itda_cmd_t cmd;
	itda_pkg::itda_sts_t sts;

	itda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (number.valid),
		.in_ready (number.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itda_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (number.value),
		.out_ready (text.ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (text.valid),
		.character (text.character),
		.last      (text.last)
	);

endmodule

// ===== hdl/itda_chk.sv =====
`timescale 1ns / 1ps
// itda_chk: port-level checks for int_to_decimal_ascii, bound to the top level
// depends on itda_pkg

module itda_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [itda_pkg::CHAR_BITS-1:0] character,
	input logic                           last
);

	// only minus or decimal digit codes appear
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == itda_pkg::CHAR_MINUS ||
			(character >= itda_pkg::CHAR_ZERO && character <= itda_pkg::CHAR_ZERO + 6'd9)))
		else $error("itda_chk: illegal character code");

	// a minus sign is never the final character
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && character == itda_pkg::CHAR_MINUS) |-> !last)
		else $error("itda_chk: minus sign flagged last");

	// the converter is busy right after an input transfer
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("itda_chk: input accepted during conversion");

	// a stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(character) && $stable(last)))
		else $error("itda_chk: stalled output changed");

endmodule

bind int_to_decimal_ascii itda_chk u_itda_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (number.valid),
	.in_ready  (number.ready),
	.out_valid (text.valid),
	.out_ready (text.ready),
	.character (text.character),
	.last      (text.last)
);

// ===== dv/decimal_text_checker.sv =====
`timescale 1ns / 1ps
// decimal_text_checker: watches the number and text channels, spells each accepted
// value in decimal and compares it with the characters that come out
// depends on itda_pkg, itda_in_if, itda_out_if

module decimal_text_checker (
	input  logic clk,
	input  logic arst_n,
	itda_in_if   number,
	itda_out_if  text,
	output int   errors,
	output int   pending
);

	localparam int MAX_DIGITS = 20;

	typedef struct packed {
		logic [itda_pkg::CHAR_BITS-1:0] character;
		logic                           last;
	} text_char_t;

	text_char_t expected_text [$];

	// most significant first, minus sign ahead of the digits
	function automatic void spell_value(input logic [itda_pkg::VALUE_BITS-1:0] value);
		logic [itda_pkg::VALUE_BITS-1:0] magnitude;
		logic [3:0]                      digits [MAX_DIGITS];
		int                              count;
		text_char_t                      glyph;
		// negating the most negative value wraps to its exact unsigned magnitude
		magnitude = value[itda_pkg::VALUE_BITS-1] ? -value : value;
		count = 0;
		do begin
			digits[count] = 4'(magnitude % 10);
			magnitude = magnitude / 10;
			count++;
		end while (magnitude != 0 && count < MAX_DIGITS);
		if (value[itda_pkg::VALUE_BITS-1]) begin
			glyph.character = itda_pkg::CHAR_MINUS;
			glyph.last = 1'b0;
			expected_text.push_back(glyph);
		end
		for (int k = count - 1; k >= 0; k--) begin
			glyph.character = itda_pkg::CHAR_ZERO + itda_pkg::CHAR_BITS'(digits[k]);
			glyph.last = (k == 0);
			expected_text.push_back(glyph);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			expected_text.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (number.valid && number.ready)
				spell_value(number.value);
			if (text.valid && text.ready) begin
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected character transfer %0d last %0b",
						$time, text.character, text.last);
					errors <= errors + 1;
				end else begin
					want = expected_text.pop_front();
					if (text.character !== want.character) begin
						$display("%0t: character expected %0d actual %0d",
							$time, want.character, text.character);
						errors <= errors + 1;
					end else if (text.last !== want.last) begin
						$display("%0t: last expected %0b actual %0b",
							$time, want.last, text.last);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_text.size();
		end
	end

endmodule

// ===== dv/int_to_decimal_ascii_test.sv =====
`timescale 1ns / 1ps
// int_to_decimal_ascii_test: drives corner and random integers into the block
// under random idling on both sides, then with no idling, and gives the verdict
// depends on itda_pkg, itda_in_if, itda_out_if, int_to_decimal_ascii, decimal_text_checker

module int_to_decimal_ascii_test;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   sender_idle;
	int   receiver_idle;
	int   errors;
	int   pending;
	int   cycle_count = 0;

	itda_in_if  number ();
	itda_out_if text ();

	int_to_decimal_ascii #(.VALUE_WIDTH(itda_pkg::VALUE_BITS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number),
		.text   (text)
	);

	decimal_text_checker text_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.number  (number),
		.text    (text),
		.errors  (errors),
		.pending (pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		text.ready <= ($urandom_range(99) >= receiver_idle);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("int_to_decimal_ascii_test NOT OK");
			$finish;
		end
	end

	// mostly shifted down to a random width so every digit count shows up, sign at random
	function automatic logic [itda_pkg::VALUE_BITS-1:0] random_integer();
		logic [itda_pkg::VALUE_BITS-1:0] bits;
		bits = {$urandom, $urandom};
		if ($urandom_range(3) != 0)
			bits = bits >> $urandom_range(itda_pkg::VALUE_BITS - 1);
		if ($urandom_range(1))
			bits = -bits;
		return bits;
	endfunction

	task automatic send_value(input logic [itda_pkg::VALUE_BITS-1:0] value);
		while ($urandom_range(99) < sender_idle) begin
			number.valid <= 1'b0;
			number.value <= {$urandom, $urandom};
			@(posedge clk);
		end
		number.valid <= 1'b1;
		number.value <= value;
		@(posedge clk);
		while (!number.ready) @(posedge clk);
	endtask

	initial begin
		logic [itda_pkg::VALUE_BITS-1:0] corner [$];
		number.valid = 1'b0;
		number.value = '0;
		text.ready = 1'b0;
		sender_idle = 24;
		receiver_idle = 86;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		corner = {
			64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, 64'd99, 64'd100, -64'd100,
			64'd1234567890, -64'd1234567890, 64'd4294967296,
			64'd999999999999999999, -64'd999999999999999999, 64'd1000000000000000000,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_8000_0000
		};
		foreach (corner[i])
			send_value(corner[i]);
		repeat (40) send_value(random_integer());

		sender_idle = 86;
		receiver_idle = 24;
		repeat (50) send_value(random_integer());

		sender_idle = 0;
		receiver_idle = 0;
		repeat (50) send_value(random_integer());

		number.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);

		if (errors == 0)
			$display("int_to_decimal_ascii_test OK");
		else
			$display("int_to_decimal_ascii_test NOT OK");
		$finish;
	end

endmodule

// ===== int_to_decimal_ascii.f =====
hdl/itda_pkg.sv
hdl/itda_in_if.sv
hdl/itda_out_if.sv
hdl/itda_ctrl.sv
hdl/itda_dp.sv
hdl/int_to_decimal_ascii.sv
hdl/itda_chk.sv
dv/decimal_text_checker.sv
dv/int_to_decimal_ascii_test.sv
